// ===== rtl/core/jsv_pkg.sv =====
// Package for the JSON stream validator: phase, event, status and kind codes,
// and the queue entry type shared by the front and back parts. No dependencies.
package jsv_pkg;

    typedef enum logic [2:0] {
        PH_WAIT, PH_BKEY, PH_KEY, PH_KDONE, PH_BVAL, PH_VAL, PH_VDONE, PH_END
    } phase_t;

    localparam logic [3:0] EV_SKIP = 4'd0;
    localparam logic [3:0] EV_OBJ_OPEN = 4'd1;
    localparam logic [3:0] EV_ARR_OPEN = 4'd2;
    localparam logic [3:0] EV_KEY_BYTE = 4'd3;
    localparam logic [3:0] EV_KEY_END = 4'd4;
    localparam logic [3:0] EV_COLON = 4'd5;
    localparam logic [3:0] EV_STR_BYTE = 4'd6;
    localparam logic [3:0] EV_STR_END = 4'd7;
    localparam logic [3:0] EV_NUM_BYTE = 4'd8;
    localparam logic [3:0] EV_LIT_BYTE = 4'd9;
    localparam logic [3:0] EV_VAL_TERM = 4'd10;
    localparam logic [3:0] EV_COMMA = 4'd11;
    localparam logic [3:0] EV_ARR_CLOSE = 4'd12;
    localparam logic [3:0] EV_OBJ_CLOSE = 4'd13;
    localparam logic [3:0] EV_ERROR = 4'd14;
    localparam logic [3:0] EV_IGNORED = 4'd15;

    localparam logic [3:0] ST_RUNNING = 4'd0;
    localparam logic [3:0] ST_COMPLETE = 4'd1;
    localparam logic [3:0] ST_BAD_START = 4'd2;
    localparam logic [3:0] ST_BAD_KEY = 4'd3;
    localparam logic [3:0] ST_BAD_COLON = 4'd4;
    localparam logic [3:0] ST_BAD_TYPE = 4'd5;
    localparam logic [3:0] ST_BAD_NUMBER = 4'd6;
    localparam logic [3:0] ST_BAD_BOOL = 4'd7;
    localparam logic [3:0] ST_BAD_NULL = 4'd8;
    localparam logic [3:0] ST_BAD_ENDING = 4'd9;
    localparam logic [3:0] ST_TOO_DEEP = 4'd10;

    localparam logic [2:0] VK_NONE = 3'd0;
    localparam logic [2:0] VK_STR = 3'd1;
    localparam logic [2:0] VK_NUM = 3'd2;
    localparam logic [2:0] VK_TRUE = 3'd3;
    localparam logic [2:0] VK_FALSE = 3'd4;
    localparam logic [2:0] VK_NULL = 3'd5;

    // Byte classes worked out by the front part.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       ws;
        logic       lf;
        logic       digit_minus;
        logic       dot;
    } item_t;

    typedef struct packed {
        logic [3:0]  ev;
        logic        done;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [5:0]  level;
        logic [3:0]  status;
        logic [15:0] line;
        logic [15:0] col;
    } result_t;

endpackage

// ===== rtl/core/jsv_front.sv =====
// Front part: accepts byte transactions, classifies each byte and queues it.
// Depends on jsv_pkg.
module jsv_front import jsv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_start,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    item_t      mem_reg [2];
    logic [1:0] wptr_reg, rptr_reg;
    item_t      cls;

    always_comb begin
        cls.data = in_byte;
        cls.start = in_start;
        cls.lf = in_byte == 8'h0a;
        cls.ws = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0d || cls.lf;
        cls.digit_minus = (in_byte >= 8'h30 && in_byte <= 8'h39) || in_byte == 8'h2d;
        cls.dot = in_byte == 8'h2e;
    end

    assign q_valid = wptr_reg != rptr_reg;
    assign in_ready = (wptr_reg ^ rptr_reg) != 2'b10;
    assign q_item = mem_reg[rptr_reg[0]];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mem_reg[wptr_reg[0]] <= cls;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (in_valid && in_ready) wptr_reg <= wptr_reg + 2'd1;
            if (q_valid && q_ready) rptr_reg <= rptr_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/core/jsv_back.sv =====
// Back part: parser state machine, nesting stack and position counters, with
// a registered result. Depends on jsv_pkg.
module jsv_back import jsv_pkg::*; #(
    parameter int MAX_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [5:0] depth_limit,
    input  logic       q_valid,
    output logic       q_ready,
    input  item_t      q_item,
    output logic       r_valid,
    input  logic       r_ready,
    output result_t    r_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    phase_t          phase_reg, ph;
    logic [2:0]      vk_reg, vk;
    logic [MAX_DEPTH-1:0] kinds_reg, kinds;
    logic [DW-1:0]   depth_reg, dp;
    logic [39:0]     lit_reg, lit;
    logic [2:0]      llen_reg, llen;
    logic [15:0]     line_reg, ln;
    logic [15:0]     col_reg, cl;
    logic [3:0]      fst_reg, fst;
    logic            rv_reg;
    result_t         res_reg, res;
    logic            go;

    logic [3:0] ev;
    logic       done;
    logic [2:0] kind, k;
    logic       top, term, ok, lit_ok;
    logic [DW-1:0] lim;
    logic [7:0] b;

    assign q_ready = !rv_reg || r_ready;
    assign go = q_valid && q_ready;
    assign r_valid = rv_reg;
    assign r_data = res_reg;

    always_comb begin
        phase_t ph0;
        ph0 = phase_reg; vk = vk_reg; kinds = kinds_reg; dp = depth_reg;
        lit = lit_reg; llen = llen_reg; ln = line_reg; cl = col_reg; fst = fst_reg;
        b = q_item.data;
        if (q_item.start) begin
            ph0 = PH_WAIT; vk = VK_NONE; kinds = '0; dp = '0; lit = '0; llen = '0;
            ln = 16'd1; cl = 16'd1; fst = ST_RUNNING;
        end
        ph = ph0;
        ev = EV_SKIP; done = 1'b0; kind = VK_NONE; k = VK_NONE; ok = 1'b1;
        top = (dp == '0) ? 1'b0 : kinds[IW'(dp - DW'(1))];
        if (depth_limit == 6'd0) lim = DW'(1);
        else if (32'(depth_limit) > MAX_DEPTH) lim = DW'(MAX_DEPTH);
        else lim = DW'(depth_limit);
        term = q_item.ws || b == 8'h2c || b == 8'h5d || b == 8'h7d;
        lit_ok = 1'b0;
        if (ph0 == PH_END) begin
            ev = EV_IGNORED;
        end else begin
            if (q_item.lf) begin
                if (ln != 16'hffff) ln = ln + 16'd1;
                cl = 16'd1;
            end
            if (cl != 16'hffff) cl = cl + 16'd1;
            if (!(ph0 == PH_VAL || ph0 == PH_KEY) && q_item.ws) begin
                ev = EV_SKIP;
            end else begin
                unique case (ph0)
                    PH_WAIT: begin
                        if (b != 8'h7b) begin
                            fst = ST_BAD_START; ph = PH_END; ev = EV_ERROR;
                        end else if (dp >= lim) begin
                            fst = ST_TOO_DEEP; ph = PH_END; ev = EV_ERROR;
                        end else begin
                            kinds[IW'(dp)] = 1'b0; dp = dp + DW'(1);
                            ph = PH_BKEY; ev = EV_OBJ_OPEN;
                        end
                    end
                    PH_BKEY: begin
                        if (b != 8'h22) begin
                            fst = ST_BAD_KEY; ph = PH_END; ev = EV_ERROR;
                        end else ph = PH_KEY;
                    end
                    PH_KEY: begin
                        if (b == 8'h22) begin
                            ph = PH_KDONE; ev = EV_KEY_END;
                        end else ev = EV_KEY_BYTE;
                    end
                    PH_KDONE: begin
                        if (b != 8'h3a) begin
                            fst = ST_BAD_COLON; ph = PH_END; ev = EV_ERROR;
                        end else begin
                            ph = PH_BVAL; ev = EV_COLON;
                        end
                    end
                    PH_BVAL: begin
                        lit = '0; llen = '0;
                        if (b == 8'h22) begin
                            vk = VK_STR; ph = PH_VAL;
                        end else if (b == 8'h5b || b == 8'h7b) begin
                            if (dp >= lim) begin
                                fst = ST_TOO_DEEP; ph = PH_END; ev = EV_ERROR;
                            end else begin
                                kinds[IW'(dp)] = (b == 8'h5b); dp = dp + DW'(1);
                                ph = (b == 8'h5b) ? PH_BVAL : PH_BKEY;
                                ev = (b == 8'h5b) ? EV_ARR_OPEN : EV_OBJ_OPEN;
                            end
                        end else if (q_item.digit_minus) begin
                            vk = VK_NUM; ph = PH_VAL; ev = EV_NUM_BYTE;
                        end else if (b == 8'h74 || b == 8'h66 || b == 8'h6e) begin
                            vk = (b == 8'h6e) ? VK_NULL : VK_TRUE;
                            lit = {32'd0, b}; llen = 3'd1;
                            ph = PH_VAL; ev = EV_LIT_BYTE;
                        end else begin
                            fst = ST_BAD_TYPE; ph = PH_END; ev = EV_ERROR;
                        end
                    end
                    PH_VAL, PH_VDONE: begin
                        if (ph0 == PH_VAL && vk == VK_STR) begin
                            if (b == 8'h22) begin
                                ph = PH_VDONE; done = 1'b1; kind = VK_STR;
                                ev = EV_STR_END;
                            end else ev = EV_STR_BYTE;
                        end else if (ph0 == PH_VAL && !term) begin
                            if (vk == VK_NUM) begin
                                if (!(q_item.digit_minus || q_item.dot)) begin
                                    fst = ST_BAD_NUMBER; ph = PH_END; ev = EV_ERROR;
                                end else ev = EV_NUM_BYTE;
                            end else begin
                                case (llen)
                                    3'd0: lit[7:0] = b;
                                    3'd1: lit[15:8] = b;
                                    3'd2: lit[23:16] = b;
                                    3'd3: lit[31:24] = b;
                                    3'd4: lit[39:32] = b;
                                    default: ;
                                endcase
                                if (llen != 3'd7) llen = llen + 3'd1;
                                ev = EV_LIT_BYTE;
                            end
                        end else begin
                            if (ph0 == PH_VAL) begin
                                if (vk == VK_NUM) k = VK_NUM;
                                else if (vk == VK_TRUE) begin
                                    if (llen == 3'd4 && lit[31:0] == 32'h65757274)
                                        k = VK_TRUE;
                                    else if (llen == 3'd5 && lit == 40'h65736c6166)
                                        k = VK_FALSE;
                                    else begin
                                        ok = 1'b0; fst = ST_BAD_BOOL;
                                    end
                                end else begin
                                    if (llen == 3'd4 && lit[31:0] == 32'h6c6c756e)
                                        k = VK_NULL;
                                    else begin
                                        ok = 1'b0; fst = ST_BAD_NULL;
                                    end
                                end
                                lit_ok = ok;
                            end
                            if (!ok) begin
                                ph = PH_END; ev = EV_ERROR;
                            end else if (ph0 == PH_VAL && q_item.ws) begin
                                ph = PH_VDONE; done = 1'b1; kind = k; ev = EV_VAL_TERM;
                            end else if (b == 8'h2c) begin
                                ph = top ? PH_BVAL : PH_BKEY; ev = EV_COMMA;
                            end else if (b == 8'h5d && dp != '0 && top) begin
                                dp = dp - DW'(1); ph = PH_VDONE; ev = EV_ARR_CLOSE;
                            end else if (b == 8'h7d && dp != '0 && !top) begin
                                dp = dp - DW'(1); ev = EV_OBJ_CLOSE;
                                if (dp == '0) begin
                                    fst = ST_COMPLETE; ph = PH_END;
                                end else ph = PH_VDONE;
                            end else begin
                                fst = ST_BAD_ENDING; ph = PH_END; ev = EV_ERROR;
                            end
                            if (lit_ok && ev != EV_ERROR && ev != EV_VAL_TERM) begin
                                done = 1'b1; kind = k;
                            end
                        end
                    end
                    default: begin
                        fst = ST_BAD_ENDING; ph = PH_END; ev = EV_ERROR;
                    end
                endcase
            end
        end
        res.ev = ev; res.done = done; res.kind = kind; res.data = b;
        res.level = 6'(dp); res.status = fst; res.line = ln; res.col = cl;
    end

    always_ff @(posedge aclk) begin
        if (go) res_reg <= res;
        if (!aresetn) begin
            phase_reg <= PH_WAIT; vk_reg <= VK_NONE; kinds_reg <= '0;
            depth_reg <= '0; lit_reg <= '0; llen_reg <= '0;
            line_reg <= 16'd1; col_reg <= 16'd1; fst_reg <= ST_RUNNING;
            rv_reg <= 1'b0;
        end else begin
            if (go) begin
                phase_reg <= ph; vk_reg <= vk; kinds_reg <= kinds; depth_reg <= dp;
                lit_reg <= lit; llen_reg <= llen; line_reg <= ln; col_reg <= cl;
                fst_reg <= fst;
                rv_reg <= 1'b1;
            end else if (r_ready) rv_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/json_stream_validator.sv =====
// A byte transaction gives its event transaction after passing through the
// classifying queue and then the parser's result register.
// Throughput: one byte per cycle while m_tready does not stall the output.
// Reset (aresetn low, synchronous) empties the queue and result register and
// returns the parser to waiting for the opening brace with depth_limit 32.
// Depends on jsv_pkg, jsv_front and jsv_back.
module json_stream_validator import jsv_pkg::*; #(
    parameter int MAX_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: depth_limit write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // doc_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // From bit 0: event_res[3:0], value_done, scalar_kind[2:0], byte_echo[7:0],
    // nest_level[5:0], status[3:0], line_number[15:0], column_number[15:0];
    // padded with zeros to 64 bits.
    output logic [63:0] m_tdata
);

    logic [5:0] limit_reg;
    logic       q_valid, q_ready;
    item_t      q_item;
    result_t    r;

    // The limit register is always ready; the user must write it only while idle (not enforced here).
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= 6'd32;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    jsv_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_start(s_tuser),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    jsv_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .depth_limit(limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
    );

    // Pack the result fields, first field lowest.
    assign m_tdata = {6'b000000, r.col, r.line, r.status, r.level, r.data, r.kind,
                      r.done, r.ev};

endmodule
